### rtl/core/srcfc_pkg.sv
// Shared types and constants for the sensor reply CRC frame check.
`default_nettype none

package srcfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame lengths in bytes, CRC bytes included
    localparam logic [3:0] MEAS_LEN = 4'd8;
    localparam logic [3:0] INFO_LEN = 4'd12;

    // Frame mode register codes
    localparam logic MODE_MEAS = 1'b0;
    localparam logic MODE_INFO = 1'b1;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_CRC_FAIL = 1'b1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic               status;
        logic [15:0]        humidity_raw;
        logic signed [15:0] temperature_raw;
        logic [63:0]        info_data;
        logic [15:0]        computed_crc;
        logic [15:0]        received_crc;
    } out_beat_t;

endpackage

`default_nettype wire

### rtl/core/srcfc_crc16.sv
// Byte-wide CRC-16/MODBUS update, eight reflected shift steps unrolled.
`default_nettype none

module srcfc_crc16 (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic [15:0]      crc_out
);
    import srcfc_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

### rtl/core/srcfc_frame.sv
// Frame tracker: byte count, running CRC, payload capture and result build.
`default_nettype none

module srcfc_frame (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire srcfc_pkg::in_beat_t beat,
    input  wire logic              frame_mode,
    output logic                   emit,
    output srcfc_pkg::out_beat_t   result
);
    import srcfc_pkg::*;

    logic [15:0] crc_reg,     crc_next;
    logic [3:0]  count_reg,   count_next;
    logic [63:0] payload_reg, payload_next;
    logic [7:0]  low_reg,     low_next;
    logic        done_reg,    done_next;

    logic [15:0] crc_cur;
    logic [15:0] crc_upd;
    logic [3:0]  len;
    logic [15:0] rx_crc;

    // A start beat sees a fresh CRC
    assign crc_cur = beat.frame_start ? CRC_INIT : crc_reg;
    assign len     = (frame_mode == MODE_INFO) ? INFO_LEN : MEAS_LEN;
    assign rx_crc  = {beat.byte_value, low_reg};

    srcfc_crc16 u_crc (
        .crc_in  (crc_cur),
        .data_in (beat.byte_value),
        .crc_out (crc_upd)
    );

    always_comb begin
        logic [3:0]  p;
        logic [63:0] pay;
        logic        dn;
        pay = beat.frame_start ? 64'd0 : payload_reg;
        dn  = beat.frame_start ? 1'b0  : done_reg;
        p   = beat.frame_start ? 4'd0  : count_reg;

        crc_next     = crc_cur;
        count_next   = p;
        payload_next = pay;
        low_next     = beat.frame_start ? 8'h00 : low_reg;
        done_next    = dn;
        emit         = 1'b0;

        result                 = '0;
        result.computed_crc    = crc_cur;
        result.received_crc    = rx_crc;
        result.status          = (rx_crc != crc_cur) ? STATUS_CRC_FAIL : STATUS_OK;
        if (frame_mode == MODE_INFO) begin
            result.info_data = pay;
        end else begin
            result.humidity_raw    = pay[31:16];
            result.temperature_raw = $signed(pay[15:0]);
        end

        if (!dn) begin
            if (p >= len) begin
                // Mode shrank the frame under us: end it silently
                done_next = 1'b1;
            end else if (p < len - 4'd2) begin
                crc_next   = crc_upd;
                count_next = p + 4'd1;
                if (p >= 4'd2) begin
                    payload_next = {pay[55:0], beat.byte_value};
                end
            end else if (p == len - 4'd2) begin
                low_next   = beat.byte_value;
                count_next = p + 4'd1;
            end else begin
                count_next = p + 4'd1;
                done_next  = 1'b1;
                emit       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRC_INIT;
            count_reg   <= 4'd0;
            payload_reg <= 64'd0;
            low_reg     <= 8'h00;
            done_reg    <= 1'b1;
        end else if (step) begin
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            payload_reg <= payload_next;
            low_reg     <= low_next;
            done_reg    <= done_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sensor_reply_crc_frame_check_core.sv
// Top level of the sensor reply CRC-16/MODBUS frame checker.
`default_nettype none

// Takes one reply byte per input beat and checks each frame against its
// trailing CRC-16/MODBUS (init 0xFFFF, reflected poly 0xA001, no final xor),
// received low byte first. A beat with frame_start set opens a new frame.
// frame_mode selects an 8-byte measurement reply (humidity and signed
// temperature out) or a 12-byte info reply (8 data bytes out, first on top).
// On the last byte of a frame one result beat is produced, with status 0 on
// a CRC match and 1 on a mismatch; bytes outside a frame produce nothing.
// Throughput is one byte per cycle while no result waits: the byte-wide CRC
// update is a single shallow xor network between the input register and the
// running CRC register. A frame's last byte passes the input register and
// then the result register on its way out. While a result waits, the input
// register takes one more byte and holds it; the input then stalls until the
// waiting result beat is taken. Write frame_mode only while the block is idle.

module sensor_reply_crc_frame_check_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input byte channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire srcfc_pkg::in_beat_t  s_data,
    // Result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output srcfc_pkg::out_beat_t      m_data,
    // frame_mode register write
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data
);
    import srcfc_pkg::*;

    logic     mode_reg;
    logic     in_valid_reg;
    in_beat_t in_data_reg;
    logic     out_valid_reg;
    out_beat_t out_data_reg;

    logic      advance;
    logic      emit;
    out_beat_t result;

    // Advance the held beat whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    srcfc_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .beat       (in_data_reg),
        .frame_mode (mode_reg),
        .emit       (emit),
        .result     (result)
    );

    // Mode register: written straight from the config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MEAS;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Input register: hold a beat until the frame tracker consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register: load on a frame end, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

### rtl/core/srcfc_checker.sv
// Port-level checker for the frame check core, bound to the top level.
`default_nettype none

module srcfc_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire srcfc_pkg::out_beat_t m_data
);
    import srcfc_pkg::*;

    // A result beat stays up until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before it was taken");

    // Status must agree with the two CRC fields
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status == STATUS_CRC_FAIL) ==
                     (m_data.computed_crc != m_data.received_crc)))
        else $error("status disagrees with CRC fields");

    // Only one mode's data fields may be populated
    a_mode_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.info_data == 64'd0) ||
                    (m_data.humidity_raw == 16'd0 && m_data.temperature_raw == 16'sd0))
        else $error("fields of both frame modes populated");

    // Out of reset: no result pending, input open
    a_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid && s_ready)
        else $error("result or stall visible right after reset");

endmodule

bind sensor_reply_crc_frame_check_core srcfc_checker u_srcfc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
